// ===== design/plra_pkg.sv =====
// ----------------------------------------------------------------------------
// plra_pkg
// Shared types and constants for the paged linked record allocator.
// ----------------------------------------------------------------------------
package plra_pkg;

   localparam int MAX_PAGES      = 64;
   localparam int SLOTS_PER_PAGE = 8;
   localparam int DATA_BITS      = 32;

   localparam int PAGE_W = $clog2(MAX_PAGES);       // page number
   localparam int SLOT_W = $clog2(SLOTS_PER_PAGE);  // slot within page
   localparam int REC_W  = PAGE_W + SLOT_W;         // record address
   localparam int IDX_W  = 10;                      // signed record index
   localparam int PTR_W  = PAGE_W + 1;              // signed page pointer
   localparam int CNT_W  = $clog2(SLOTS_PER_PAGE + 1);
   localparam int NUM_W  = REC_W + 1;               // walk counter

   localparam logic [IDX_W-1:0] IDX_NONE = '1;
   localparam logic [PTR_W-1:0] PTR_NONE = '1;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_FULL = 2'd1;
   localparam logic [1:0] STS_RO   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AH0, ST_AH1, ST_AP0, ST_AP1, ST_AP2, ST_AU0, ST_AU1,
      ST_OPEN, ST_ALINK, ST_F0, ST_F1, ST_F2, ST_R0, ST_R1, ST_DONE
   } state_type;

   typedef struct packed {
      logic [PTR_W-1:0] next;
      logic [PTR_W-1:0] prev;
      logic [IDX_W-1:0] first;
      logic [CNT_W-1:0] cnt;
   } page_ent_type;

   typedef struct packed {
      logic [PAGE_W-1:0] addr;
      logic              we_next;
      logic              we_prev;
      logic              we_first;
      logic              we_cnt;
      page_ent_type      ent;
   } page_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0]     link;
      logic [DATA_BITS-1:0] pay;
   } rec_ent_type;

   typedef struct packed {
      logic                 link_we;
      logic [REC_W-1:0]     link_addr;
      logic [IDX_W-1:0]     link_data;
      logic                 pay_we;
      logic [REC_W-1:0]     pay_addr;
      logic [DATA_BITS-1:0] pay_data;
   } rec_wr_type;

   function automatic logic rec_ok(logic [IDX_W-1:0] x, logic [PTR_W-1:0] pages);
      logic [IDX_W-1:0] lim;
      lim = IDX_W'({pages, {SLOT_W{1'b0}}});
      return !x[IDX_W-1] && (x < lim);
   endfunction

   function automatic logic page_ok(logic [PTR_W-1:0] p, logic [PTR_W-1:0] pages);
      return !p[PTR_W-1] && (p < pages);
   endfunction

endpackage

// ===== design/paged_linked_record_allocator.sv =====
// ----------------------------------------------------------------------------
// paged_linked_record_allocator
// Paged record store with per-page free chains and a list of pages with room.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  req_    | in        | tuser: req_type; tdata: rec_index, hint, data
//  rsp_    | out       | tuser: status;   tdata: rec_out, data_out
//  csr_    | in        | wdata: write_enable
//
//  One item at a time. Opening a page for an append sweeps the links of all
//  its slots; a free walks the record chain record by record; refused or
//  unknown requests go straight to the response.
//  Synchronous reset clears control only.
//  A finished word waits in the output register; rsp_tready stalls the end.
// ----------------------------------------------------------------------------
module paged_linked_record_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // rec_index[9:0], hint[19:10], data[51:20]
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // rec_out[9:0], data_out[41:10]
   output logic [1:0]  rsp_tuser    // status
);
   import plra_pkg::*;

   state_type state_ff, state_in;
   logic we_ff;
   logic [PTR_W-1:0] pages_ff, pages_in, head_ff, head_in, oh_ff, oh_in;
   logic [IDX_W-1:0] idx_ff, idx_in, h_ff, h_in, cur_ff, cur_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [PAGE_W-1:0] p_ff, p_in;
   logic [REC_W-1:0]  r_ff, r_in;
   logic [SLOT_W-1:0] k_ff, k_in;
   logic [1:0]  res_sts_ff, res_sts_in;
   logic [IDX_W-1:0] res_rec_ff, res_rec_in;
   logic [31:0] res_dat_ff, res_dat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0]  out_sts_ff, out_sts_in;
   logic [IDX_W-1:0] out_rec_ff, out_rec_in;
   logic [31:0] out_dat_ff, out_dat_in;

   logic prd_en, rrd_en;
   logic [PAGE_W-1:0] prd_addr;
   logic [REC_W-1:0]  rrd_addr;
   page_ent_type pent;
   rec_ent_type  rent;
   page_wr_type  pw;
   rec_wr_type   rw;

   logic [IDX_W-1:0] in_idx, in_hint;
   logic [SLOT_W-1:0] sl;
   logic [CNT_W-1:0] newcnt;

   assign in_idx  = req_tdata[9:0];
   assign in_hint = req_tdata[19:10];

   plra_page_mem u_page (
      .clock(clock), .rd_en(prd_en), .rd_addr(prd_addr), .rd_data(pent), .wr(pw)
   );
   plra_rec_mem u_rec (
      .clock(clock), .rd_en(rrd_en), .rd_addr(rrd_addr), .rd_data(rent), .wr(rw)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_sts_ff;
   assign rsp_tdata  = {6'd0, out_dat_ff, out_rec_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         we_ff        <= 1'b1;
         pages_ff     <= '0;
         head_ff      <= PTR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) we_ff <= csr_wdata;
         pages_ff     <= pages_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      oh_ff      <= oh_in;
      idx_ff     <= idx_in;
      h_ff       <= h_in;
      cur_ff     <= cur_in;
      data_ff    <= data_in;
      n_ff       <= n_in;
      p_ff       <= p_in;
      r_ff       <= r_in;
      k_ff       <= k_in;
      res_sts_ff <= res_sts_in;
      res_rec_ff <= res_rec_in;
      res_dat_ff <= res_dat_in;
      out_sts_ff <= out_sts_in;
      out_rec_ff <= out_rec_in;
      out_dat_ff <= out_dat_in;
   end

   always_comb begin
      state_in     = state_ff;
      pages_in     = pages_ff;
      head_in      = head_ff;
      oh_in        = oh_ff;
      idx_in       = idx_ff;
      h_in         = h_ff;
      cur_in       = cur_ff;
      data_in      = data_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      res_sts_in   = res_sts_ff;
      res_rec_in   = res_rec_ff;
      res_dat_in   = res_dat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_sts_in   = out_sts_ff;
      out_rec_in   = out_rec_ff;
      out_dat_in   = out_dat_ff;
      prd_en       = 1'b0;
      prd_addr     = p_ff;
      rrd_en       = 1'b0;
      rrd_addr     = r_ff;
      pw           = '0;
      rw           = '0;
      sl           = (pent.first[IDX_W-1] || |pent.first[IDX_W-2:SLOT_W])
                     ? '0 : pent.first[SLOT_W-1:0];
      newcnt       = (pent.cnt != '0) ? pent.cnt - 1'b1 : pent.cnt;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in     = in_idx;
               data_in    = req_tdata[51:20];
               res_sts_in = STS_OK;
               res_rec_in = IDX_NONE;
               res_dat_in = '0;
               h_in       = rec_ok(in_idx, pages_ff) ? in_idx : in_hint;
               priority if ((req_tuser == REQ_APPEND || req_tuser == REQ_FREE) && !we_ff) begin
                  res_sts_in = STS_RO;
                  state_in   = ST_DONE;
               end else if (req_tuser == REQ_APPEND) begin
                  if (page_ok(head_ff, pages_ff)) begin
                     state_in = ST_AH0;
                  end else if (pages_ff >= PTR_W'(MAX_PAGES)) begin
                     res_sts_in = STS_FULL;
                     state_in   = ST_DONE;
                  end else begin
                     k_in     = '0;
                     state_in = ST_OPEN;
                  end
               end else if (req_tuser == REQ_FREE) begin
                  cur_in   = in_idx;
                  n_in     = '0;
                  state_in = ST_F0;
               end else if (req_tuser == REQ_READ) begin
                  state_in = ST_R0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_AH0: begin
            if (rec_ok(h_ff, pages_ff)) begin
               prd_en   = 1'b1;
               prd_addr = h_ff[REC_W-1:SLOT_W];
               state_in = ST_AH1;
            end else begin
               p_in     = head_ff[PAGE_W-1:0];
               state_in = ST_AP0;
            end
         end
         ST_AH1: begin
            p_in     = (pent.cnt != '0) ? h_ff[REC_W-1:SLOT_W] : head_ff[PAGE_W-1:0];
            state_in = ST_AP0;
         end
         ST_AP0: begin
            prd_en   = 1'b1;
            prd_addr = p_ff;
            state_in = ST_AP1;
         end
         ST_AP1: begin
            r_in     = {p_ff, sl};
            rrd_en   = 1'b1;
            rrd_addr = {p_ff, sl};
            state_in = ST_AP2;
         end
         ST_AP2: begin
            rw.link_we    = 1'b1;
            rw.link_addr  = r_ff;
            rw.link_data  = IDX_NONE;
            pw.addr       = p_ff;
            pw.we_first   = 1'b1;
            pw.ent.first  = rent.link;
            pw.we_cnt     = 1'b1;
            pw.ent.cnt    = newcnt;
            state_in      = (newcnt == '0) ? ST_AU0 : ST_ALINK;
         end
         ST_AU0: begin
            if (page_ok(pent.prev, pages_ff)) begin
               pw.addr     = pent.prev[PAGE_W-1:0];
               pw.we_next  = 1'b1;
               pw.ent.next = pent.next;
            end else begin
               head_in = pent.next;
            end
            state_in = ST_AU1;
         end
         ST_AU1: begin
            if (page_ok(pent.next, pages_ff)) begin
               pw.addr     = pent.next[PAGE_W-1:0];
               pw.we_prev  = 1'b1;
               pw.ent.prev = pent.prev;
            end
            state_in = ST_ALINK;
         end
         ST_OPEN: begin
            rw.link_we   = 1'b1;
            rw.link_addr = {pages_ff[PAGE_W-1:0], k_ff};
            rw.link_data = (k_ff == '0 || k_ff == SLOT_W'(SLOTS_PER_PAGE - 1))
                           ? IDX_NONE : IDX_W'(k_ff) + 1'b1;
            if (k_ff == '0) begin
               pw.addr      = pages_ff[PAGE_W-1:0];
               pw.we_next   = 1'b1;
               pw.we_prev   = 1'b1;
               pw.we_first  = 1'b1;
               pw.we_cnt    = 1'b1;
               pw.ent.next  = PTR_NONE;
               pw.ent.prev  = PTR_NONE;
               pw.ent.first = IDX_W'(1);
               pw.ent.cnt   = CNT_W'(SLOTS_PER_PAGE - 1);
            end
            if (k_ff == SLOT_W'(SLOTS_PER_PAGE - 1)) begin
               pages_in = pages_ff + 1'b1;
               head_in  = pages_ff;
               r_in     = {pages_ff[PAGE_W-1:0], {SLOT_W{1'b0}}};
               state_in = ST_ALINK;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_ALINK: begin
            if (rec_ok(idx_ff, pages_ff)) begin
               rw.link_we   = 1'b1;
               rw.link_addr = idx_ff[REC_W-1:0];
               rw.link_data = IDX_W'(r_ff);
            end
            rw.pay_we   = 1'b1;
            rw.pay_addr = r_ff;
            rw.pay_data = data_ff;
            res_rec_in  = IDX_W'(r_ff);
            state_in    = ST_DONE;
         end
         ST_F0: begin
            if (rec_ok(cur_ff, pages_ff) && !n_ff[NUM_W-1]) begin
               rrd_en   = 1'b1;
               rrd_addr = cur_ff[REC_W-1:0];
               prd_en   = 1'b1;
               prd_addr = cur_ff[REC_W-1:SLOT_W];
               p_in     = cur_ff[REC_W-1:SLOT_W];
               state_in = ST_F1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_F1: begin
            cur_in   = rent.link;
            n_in     = n_ff + 1'b1;
            state_in = ST_F0;
            if (pent.cnt >= CNT_W'(SLOTS_PER_PAGE)) begin
               state_in = ST_F0;
            end else if (pent.cnt == '0) begin
               pw.addr      = p_ff;
               pw.we_next   = 1'b1;
               pw.we_prev   = 1'b1;
               pw.we_first  = 1'b1;
               pw.we_cnt    = 1'b1;
               pw.ent.next  = head_ff;
               pw.ent.prev  = PTR_NONE;
               pw.ent.first = IDX_W'(cur_ff[SLOT_W-1:0]);
               pw.ent.cnt   = CNT_W'(1);
               rw.link_we   = 1'b1;
               rw.link_addr = cur_ff[REC_W-1:0];
               rw.link_data = IDX_NONE;
               head_in      = PTR_W'(p_ff);
               oh_in        = head_ff;
               if (page_ok(head_ff, pages_ff)) state_in = ST_F2;
            end else begin
               rw.link_we   = 1'b1;
               rw.link_addr = cur_ff[REC_W-1:0];
               rw.link_data = pent.first;
               pw.addr      = p_ff;
               pw.we_first  = 1'b1;
               pw.ent.first = IDX_W'(cur_ff[SLOT_W-1:0]);
               pw.we_cnt    = 1'b1;
               pw.ent.cnt   = pent.cnt + 1'b1;
            end
         end
         ST_F2: begin
            pw.addr     = oh_ff[PAGE_W-1:0];
            pw.we_prev  = 1'b1;
            pw.ent.prev = PTR_W'(p_ff);
            state_in    = ST_F0;
         end
         ST_R0: begin
            if (rec_ok(idx_ff, pages_ff)) begin
               rrd_en   = 1'b1;
               rrd_addr = idx_ff[REC_W-1:0];
               state_in = ST_R1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_R1: begin
            res_rec_in = rent.link;
            res_dat_in = rent.pay[31:0];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_sts_in   = res_sts_ff;
               out_rec_in   = res_rec_ff;
               out_dat_in   = res_dat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/plra_page_mem.sv =====
// ----------------------------------------------------------------------------
// plra_page_mem
// Per-page table: free list links, first free slot and free count.
// ----------------------------------------------------------------------------
module plra_page_mem (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [plra_pkg::PAGE_W-1:0]   rd_addr,
   output plra_pkg::page_ent_type        rd_data,
   input  plra_pkg::page_wr_type         wr
);
   import plra_pkg::*;

   logic [PTR_W-1:0] next_mem  [MAX_PAGES];
   logic [PTR_W-1:0] prev_mem  [MAX_PAGES];
   logic [IDX_W-1:0] first_mem [MAX_PAGES];
   logic [CNT_W-1:0] cnt_mem   [MAX_PAGES];

   always_ff @(posedge clock) begin
      if (wr.we_next)  next_mem[wr.addr]  <= wr.ent.next;
      if (wr.we_prev)  prev_mem[wr.addr]  <= wr.ent.prev;
      if (wr.we_first) first_mem[wr.addr] <= wr.ent.first;
      if (wr.we_cnt)   cnt_mem[wr.addr]   <= wr.ent.cnt;
      if (rd_en) begin
         rd_data.next  <= next_mem[rd_addr];
         rd_data.prev  <= prev_mem[rd_addr];
         rd_data.first <= first_mem[rd_addr];
         rd_data.cnt   <= cnt_mem[rd_addr];
      end
   end

endmodule

// ===== design/plra_rec_mem.sv =====
// ----------------------------------------------------------------------------
// plra_rec_mem
// Per-record store: next link and payload.
// ----------------------------------------------------------------------------
module plra_rec_mem (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [plra_pkg::REC_W-1:0]   rd_addr,
   output plra_pkg::rec_ent_type        rd_data,
   input  plra_pkg::rec_wr_type         wr
);
   import plra_pkg::*;

   localparam int NUM_RECS = MAX_PAGES * SLOTS_PER_PAGE;

   logic [IDX_W-1:0]     link_mem [NUM_RECS];
   logic [DATA_BITS-1:0] pay_mem  [NUM_RECS];

   always_ff @(posedge clock) begin
      if (wr.link_we) link_mem[wr.link_addr] <= wr.link_data;
      if (wr.pay_we)  pay_mem[wr.pay_addr]   <= wr.pay_data;
      if (rd_en) begin
         rd_data.link <= link_mem[rd_addr];
         rd_data.pay  <= pay_mem[rd_addr];
      end
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the paged linked record allocator: a behavioural copy of the
// page and record tables predicts every response word, which is checked field
// by field against the block while both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import plra_pkg::*;

   localparam int NREC     = MAX_PAGES * SLOTS_PER_PAGE;
   localparam int WDOG     = 20000;
   localparam int HOLD_LEN = 400;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  idx;
      logic [9:0]  hint;
      logic [31:0] data;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  rec;
      logic [31:0] payload;
   } rsp_word_type;

   logic        clock, reset;
   logic        csr_valid, csr_ready, csr_wdata;
   logic        req_tvalid, req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   paged_linked_record_allocator u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // allocator shadow, cleared as after reset
   bit          wr_en = 1;
   int          pages_used = 0;
   int          list_head = -1;
   int          pg_next[MAX_PAGES], pg_prev[MAX_PAGES];
   int          pg_first[MAX_PAGES], pg_cnt[MAX_PAGES];
   int          link_tab[NREC];
   bit [31:0]   pay_tab[NREC];

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   int          errors = 0, n_rsp = 0, n_full = 0, n_ro = 0;
   int          send_idle, recv_idle;
   int          hold_cycles, stall_cnt;
   bit          hold_go = 0;

   function automatic bit pg_in_use(int p);
      return p >= 0 && p < pages_used;
   endfunction

   function automatic bit rec_in_use(int r);
      return r >= 0 && r < pages_used * SLOTS_PER_PAGE;
   endfunction

   function automatic void drop_page(int p);
      if (pg_in_use(pg_prev[p])) pg_next[pg_prev[p]] = pg_next[p];
      else list_head = pg_next[p];
      if (pg_in_use(pg_next[p])) pg_prev[pg_next[p]] = pg_prev[p];
   endfunction

   function automatic int grab_slot(int p);
      int s, r;
      s = pg_first[p];
      if (s < 0 || s >= SLOTS_PER_PAGE) s = 0;
      r = p * SLOTS_PER_PAGE + s;
      pg_first[p] = link_tab[r];
      link_tab[r] = -1;
      if (pg_cnt[p] > 0) pg_cnt[p]--;
      if (pg_cnt[p] == 0) drop_page(p);
      return r;
   endfunction

   function automatic int place_record(int h);
      int p;
      if (!pg_in_use(list_head)) begin
         if (pages_used >= MAX_PAGES) return -1;
         p = pages_used;
         pages_used++;
         for (int i = 0; i < SLOTS_PER_PAGE; i++)
            link_tab[p*SLOTS_PER_PAGE+i] = (i == 0 || i == SLOTS_PER_PAGE-1) ? -1 : i+1;
         pg_next[p] = -1;
         pg_prev[p] = -1;
         pg_cnt[p] = SLOTS_PER_PAGE - 1;
         pg_first[p] = 1;
         list_head = p;
         return p * SLOTS_PER_PAGE;
      end
      if (rec_in_use(h) && pg_cnt[h / SLOTS_PER_PAGE] > 0)
         return grab_slot(h / SLOTS_PER_PAGE);
      return grab_slot(list_head);
   endfunction

   function automatic void return_slot(int r);
      int p, s;
      p = r / SLOTS_PER_PAGE;
      s = r % SLOTS_PER_PAGE;
      if (pg_cnt[p] >= SLOTS_PER_PAGE) return;
      if (pg_cnt[p] == 0) begin
         pg_prev[p] = -1;
         pg_next[p] = list_head;
         if (pg_in_use(list_head)) pg_prev[list_head] = p;
         list_head = p;
         pg_cnt[p] = 1;
         pg_first[p] = s;
         link_tab[r] = -1;
      end else begin
         link_tab[r] = pg_first[p];
         pg_first[p] = s;
         pg_cnt[p]++;
      end
   endfunction

   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type o;
      int idx, hint, h, r, cur, nxt, n;
      idx = $signed(w.idx);
      hint = $signed(w.hint);
      o = '{status: STS_OK, rec: IDX_NONE, payload: '0};
      if ((w.kind == REQ_APPEND || w.kind == REQ_FREE) && !wr_en) begin
         o.status = STS_RO;
      end else if (w.kind == REQ_APPEND) begin
         h = rec_in_use(idx) ? idx : hint;
         r = place_record(h);
         if (r < 0) begin
            o.status = STS_FULL;
         end else begin
            if (rec_in_use(idx)) link_tab[idx] = r;
            pay_tab[r] = w.data;
            o.rec = 10'(r);
         end
      end else if (w.kind == REQ_FREE) begin
         cur = idx;
         n = 0;
         while (rec_in_use(cur) && n < NREC) begin
            nxt = link_tab[cur];
            return_slot(cur);
            cur = nxt;
            n++;
         end
      end else if (w.kind == REQ_READ) begin
         if (rec_in_use(idx)) begin
            o.rec = 10'(link_tab[idx]);
            o.payload = pay_tab[idx];
         end
      end
      return o;
   endfunction

   // stimulus helpers
   function automatic void add_req(logic [1:0] k, int idx, int hint, logic [31:0] d);
      pending_reqs.push_back('{kind: k, idx: 10'(idx), hint: 10'(hint), data: d});
   endfunction

   function automatic int pick_idx();
      int lim;
      lim = (pages_used + 1) * SLOTS_PER_PAGE;
      case ($urandom_range(0, 9))
         0:       return -1;
         1:       return $signed(10'($urandom));
         default: return $urandom_range(0, lim > NREC ? NREC-1 : lim-1);
      endcase
   endfunction

   function automatic void add_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 19);
         if (k < 10) add_req(REQ_APPEND, pick_idx(), pick_idx(), $urandom);
         else if (k < 13) add_req(REQ_FREE, pick_idx(), pick_idx(), $urandom);
         else if (k < 19) add_req(REQ_READ, pick_idx(), pick_idx(), $urandom);
         else add_req(REQ_UNKNOWN, pick_idx(), pick_idx(), $urandom);
      end
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            req_word_type w;
            w = pending_reqs.pop_front();
            expected_rsps.push_back(predict_rsp(w));
            req_tvalid <= 1;
            req_tuser  <= w.kind;
            req_tdata  <= {4'b0, w.data, w.hint, w.idx};
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver hold-off counter
   always @(posedge clock) begin
      if (reset) hold_cycles <= 0;
      else if (hold_go) hold_cycles <= HOLD_LEN;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_word_type got, exp;
            got = '{status: rsp_tuser, rec: rsp_tdata[9:0], payload: rsp_tdata[41:10]};
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected word status=%0d rec=%0d data=%h", $time,
                        got.status, $signed(got.rec), got.payload);
               errors++;
            end else begin
               exp = expected_rsps.pop_front();
               if (exp.status == STS_FULL) n_full++;
               if (exp.status == STS_RO) n_ro++;
               if (got.status !== exp.status) begin
                  $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                  errors++;
               end
               if (got.rec !== exp.rec) begin
                  $display("%0t: rec_out exp %0d got %0d", $time,
                           $signed(exp.rec), $signed(got.rec));
                  errors++;
               end
               if (got.payload !== exp.payload) begin
                  $display("%0t: data_out exp %h got %h", $time, exp.payload, got.payload);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          hold_cycles > 0) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= WDOG) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(bit v);
      csr_valid <= 1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      wr_en = v;
   endtask

   initial begin
      reset = 1;
      csr_valid = 0; csr_wdata = 0;
      send_idle = 27; recv_idle = 58;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: edge cases
      add_req(REQ_READ, -1, -1, '0);
      add_req(REQ_READ, 511, 0, '0);
      add_req(REQ_FREE, -1, 0, '0);
      add_req(REQ_UNKNOWN, 0, 0, 32'hFFFF_FFFF);
      add_req(REQ_APPEND, -1, -1, 32'hFFFF_FFFF);
      add_req(REQ_APPEND, 0, -1, 32'h0000_0000);
      add_req(REQ_APPEND, 1, 0, 32'hA5A5_5A5A);
      add_req(REQ_APPEND, -512, 511, 32'h5A5A_A5A5);
      add_req(REQ_READ, 0, -1, '0);
      add_req(REQ_READ, 1, -1, '0);
      add_req(REQ_FREE, 0, -1, '0);
      add_req(REQ_FREE, 0, -1, '0);     // double free
      add_req(REQ_FREE, 5, -1, '0);     // record never taken
      add_req(REQ_APPEND, -1, 3, 32'h1234_5678);
      add_req(REQ_READ, 2, -1, '0);
      drain();

      write_csr(0);
      add_req(REQ_APPEND, -1, -1, 32'hDEAD_BEEF);
      add_req(REQ_FREE, 1, -1, '0);
      add_req(REQ_READ, 1, -1, '0);
      drain();
      write_csr(1);

      // long receiver hold while the sender keeps offering
      send_idle = 0;
      add_random(30);
      hold_go <= 1;
      @(posedge clock);
      hold_go <= 0;
      drain();

      // chain frees from the first record of every other page, then random phases
      add_req(REQ_FREE, 0, -1, '0);
      for (int p = 0; p < MAX_PAGES; p += 2) add_req(REQ_FREE, p*SLOTS_PER_PAGE, -1, '0);
      send_idle = 27; recv_idle = 58;
      add_random(130);
      drain();
      write_csr(0);
      add_random(15);
      drain();
      write_csr(1);
      send_idle = 58; recv_idle = 27;
      add_random(130);
      drain();
      send_idle = 0; recv_idle = 0;
      add_random(94);
      drain();

      $display("appends, chain frees, reads, read-only refusals and a long receiver hold");
      $display("%0d words checked: %0d store-full, %0d read-only refusals, %0d mismatches",
               n_rsp, n_full, n_ro, errors);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
